// ----- rtl/hrms_pkg.sv -----
// hrms_pkg: shared types and constants for the hard-rod metropolis step unit
// no dependencies; imported by the checker and all modules but hrms_ram
package hrms_pkg;

   // rod store geometry
   localparam int MAX_RODS = 64;
   localparam int ROD_AW   = $clog2(MAX_RODS);
   localparam int CNT_W    = ROD_AW + 1;

   // field widths
   localparam int POS_W   = 32;
   localparam int DISP_W  = 24;
   localparam int PER_W   = POS_W + 1;
   localparam int SUM_W   = POS_W + 2;
   localparam int COUNT_W = 7;

   // remainder unit: one quotient bit per step over a PER_W-bit dividend
   localparam int REM_STEPS = PER_W;
   localparam int REM_CW    = $clog2(REM_STEPS);

   // configuration port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [POS_W-1:0]   BOX_RESET      = 32'd26214400;
   localparam logic [POS_W-1:0]   DIAMETER_RESET = 32'd1310720;
   localparam logic [COUNT_W-1:0] COUNT_RESET    = 7'd10;

   typedef enum logic [1:0] {
      CSR_BOX      = 2'd0,
      CSR_DIAMETER = 2'd1,
      CSR_COUNT    = 2'd2
   } csr_index_type;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_TRIAL = 1'b1;

   typedef enum logic [1:0] {
      ST_ACCEPT = 2'd0,
      ST_REJECT = 2'd1,
      ST_LOADED = 2'd2,
      ST_RANGE  = 2'd3
   } status_type;

   typedef struct packed {
      logic                     action;
      logic [ROD_AW-1:0]        rod_index;
      logic [POS_W-1:0]         position_value;
      logic signed [DISP_W-1:0] displacement;
   } req_item_type;

   typedef struct packed {
      status_type       status;
      logic [POS_W-1:0] final_position;
   } rsp_item_type;

   // dividend source of the remainder unit
   typedef enum logic [1:0] {
      DIV_SRC_PVAL = 2'd0,
      DIV_SRC_SUM  = 2'd1,
      DIV_SRC_DX   = 2'd2
   } div_src_type;

   // source of the new rod position register
   typedef enum logic [1:0] {
      VAL_PVAL = 2'd0,
      VAL_FAST = 2'd1,
      VAL_REM  = 2'd2
   } val_src_type;

   typedef struct packed {
      logic        latch_item;
      logic        rd_en;
      logic        rd_scan;
      logic        wr_en;
      logic        cap_sum;
      logic        val_ld;
      val_src_type val_src;
      logic        div_start;
      div_src_type div_src;
      logic        dx_ld;
      logic        idx_clr;
      logic        idx_inc;
      logic        ov_from_div;
      logic        emit;
      status_type  emit_code;
   } hrms_cmd_type;

   typedef struct packed {
      logic in_range;
      logic is_trial;
      logic pval_lt_per;
      logic sum_fast_ok;
      logic idx_done;
      logic idx_is_k;
      logic dx_lt_per;
      logic overlap;
      logic div_busy;
   } hrms_status_type;

endpackage

// ----- rtl/hrms_ram.sv -----
// hrms_ram: generic single-write, single-read memory with registered read data
// no dependencies; holds the rod positions of the step unit
module hrms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/hrms_rem.sv -----
// hrms_rem: restoring remainder unit, one quotient bit per cycle
// depends on hrms_pkg; used by hrms_datapath for every wrap and distance reduction
module hrms_rem
   import hrms_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [PER_W-1:0] dividend,
   input  logic [PER_W-1:0] divisor,
   output logic             busy,
   output logic [POS_W-1:0] remainder
);

   logic              busy_ff, busy_in;
   logic [REM_CW-1:0] cnt_ff, cnt_in;
   logic [PER_W-1:0]  rem_ff, rem_in;
   logic [PER_W-1:0]  dvd_ff, dvd_in;
   logic [PER_W-1:0]  dsr_ff, dsr_in;
   logic [PER_W:0]    trial;

   // one shift-and-subtract step
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, dvd_ff[PER_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = REM_CW'(REM_STEPS - 1);
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[PER_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = PER_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[PER_W-1:0];
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff[POS_W-1:0];

endmodule

// ----- rtl/hrms_datapath.sv -----
// hrms_datapath: item registers, rod store, wrap and distance arithmetic, result register
// depends on hrms_pkg, hrms_ram and hrms_rem; driven by hrms_ctrl
module hrms_datapath
   import hrms_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  req_item_type       req_data,
   input  logic [POS_W-1:0]   box_length,
   input  logic [POS_W-1:0]   rod_diameter,
   input  logic [COUNT_W-1:0] rod_count,
   input  hrms_cmd_type       cmd,
   output hrms_status_type    sts,
   output logic               rsp_strobe,
   output rsp_item_type       rsp_data
);

   req_item_type       item_ff, item_in;
   logic [POS_W-1:0]   oldpos_ff, oldpos_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [POS_W-1:0]   val_ff, val_in;
   logic [POS_W-1:0]   dx_ff, dx_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   rsp_item_type       rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;

   logic [PER_W-1:0]   per;
   logic [CNT_W-1:0]   active_n;
   logic [CNT_W-1:0]   k_ext;
   logic [POS_W-1:0]   ram_rdata;
   logic [ROD_AW-1:0]  ram_raddr;
   logic [PER_W-1:0]   div_dividend;
   logic               div_busy;
   logic [POS_W-1:0]   div_rem;
   logic               sum_neg;
   logic [SUM_W-1:0]   sum_plus;
   logic [PER_W-1:0]   sum_abs;
   logic [POS_W-1:0]   fast_val;
   logic [PER_W-1:0]   rem_adj;
   logic [POS_W-1:0]   rem_val;
   logic [POS_W-1:0]   ov_r;
   logic [PER_W-1:0]   ov_far;

   // period: a zero box length stands for 2^32
   assign per = (box_length == '0) ? {1'b1, {POS_W{1'b0}}} : {1'b0, box_length};

   // active rod count, capped at the store depth
   always_comb begin
      if (32'(rod_count) < 32'(MAX_RODS)) begin
         active_n = CNT_W'(rod_count);
      end else begin
         active_n = CNT_W'(MAX_RODS);
      end
   end

   assign k_ext = CNT_W'(item_ff.rod_index);

   // rod store
   assign ram_raddr = cmd.rd_scan ? idx_ff[ROD_AW-1:0] : item_ff.rod_index;

   hrms_ram #(
      .WIDTH (POS_W),
      .DEPTH (MAX_RODS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (item_ff.rod_index),
      .wr_data (val_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // fast wrap of the trial sum when it lies within one period of the box
   assign sum_neg  = sum_ff[SUM_W-1];
   assign sum_plus = SUM_W'(sum_ff) + SUM_W'(per);
   assign sum_abs  = sum_neg ? PER_W'(~sum_ff + 1'b1) : sum_ff[PER_W-1:0];
   assign fast_val = sum_neg ? sum_plus[POS_W-1:0] : sum_ff[POS_W-1:0];

   // remainder unit dividend select
   always_comb begin
      case (cmd.div_src)
         DIV_SRC_PVAL: div_dividend = {1'b0, item_ff.position_value};
         DIV_SRC_SUM:  div_dividend = sum_abs;
         DIV_SRC_DX:   div_dividend = {1'b0, dx_ff};
         default:      div_dividend = {1'b0, dx_ff};
      endcase
   end

   hrms_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (per),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   // negative trial sums fold back from the top of the period
   assign rem_adj = per - {1'b0, div_rem};
   always_comb begin
      if (item_ff.action == ACT_TRIAL && sum_neg && div_rem != '0) begin
         rem_val = rem_adj[POS_W-1:0];
      end else begin
         rem_val = div_rem;
      end
   end

   // overlap test on a reduced distance r: 0 < min(r, per - r) < diameter
   assign ov_r   = cmd.ov_from_div ? div_rem : dx_ff;
   assign ov_far = per - {1'b0, ov_r};

   // next values of the datapath registers
   always_comb begin
      item_in   = item_ff;
      oldpos_in = oldpos_ff;
      sum_in    = sum_ff;
      val_in    = val_ff;
      dx_in     = dx_ff;
      idx_in    = idx_ff;
      rsp_in    = rsp_ff;
      strobe_in = cmd.emit;
      if (cmd.latch_item) begin
         item_in = req_data;
      end
      if (cmd.cap_sum) begin
         oldpos_in = ram_rdata;
         sum_in    = $signed({{(SUM_W-POS_W){1'b0}}, ram_rdata})
                   + $signed({{(SUM_W-DISP_W){item_ff.displacement[DISP_W-1]}},
                              item_ff.displacement});
      end
      if (cmd.val_ld) begin
         case (cmd.val_src)
            VAL_PVAL: val_in = item_ff.position_value;
            VAL_FAST: val_in = fast_val;
            VAL_REM:  val_in = rem_val;
            default:  val_in = rem_val;
         endcase
      end
      if (cmd.dx_ld) begin
         dx_in = (val_ff > ram_rdata) ? (val_ff - ram_rdata) : (ram_rdata - val_ff);
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.emit) begin
         rsp_in.status = cmd.emit_code;
         case (cmd.emit_code)
            ST_RANGE:  rsp_in.final_position = '0;
            ST_REJECT: rsp_in.final_position = oldpos_ff;
            default:   rsp_in.final_position = val_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      item_ff   <= item_in;
      oldpos_ff <= oldpos_in;
      sum_ff    <= sum_in;
      val_ff    <= val_in;
      dx_ff     <= dx_in;
      idx_ff    <= idx_in;
      rsp_ff    <= rsp_in;
   end

   // status toward the controller
   assign sts.in_range    = k_ext < active_n;
   assign sts.is_trial    = item_ff.action == ACT_TRIAL;
   assign sts.pval_lt_per = {1'b0, item_ff.position_value} < per;
   assign sts.sum_fast_ok = sum_neg ? !sum_plus[SUM_W-1]
                                    : (sum_ff[PER_W-1:0] < per);
   assign sts.idx_done    = idx_ff >= active_n;
   assign sts.idx_is_k    = idx_ff == k_ext;
   assign sts.dx_lt_per   = {1'b0, dx_ff} < per;
   assign sts.overlap     = (ov_r != '0)
                          && ((ov_r < rod_diameter) || (ov_far < {1'b0, rod_diameter}));
   assign sts.div_busy    = div_busy;

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- rtl/hrms_ctrl.sv -----
// hrms_ctrl: sequencer for load and trial items, the overlap scan and the remainder waits
// depends on hrms_pkg; commands hrms_datapath
module hrms_ctrl
   import hrms_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  hrms_status_type sts,
   output hrms_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_LOAD_DIV,
      S_LOAD_WR,
      S_TRIAL_RD,
      S_TRIAL_SUM,
      S_TRIAL_DIV,
      S_SCAN_ISSUE,
      S_SCAN_DX,
      S_SCAN_CHK,
      S_SCAN_DIV,
      S_TRIAL_WR
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch_item = 1'b1;
               state_in       = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!sts.in_range) begin
               cmd.emit      = 1'b1;
               cmd.emit_code = ST_RANGE;
               state_in      = S_IDLE;
            end else if (sts.is_trial) begin
               cmd.rd_en = 1'b1;
               state_in  = S_TRIAL_RD;
            end else if (sts.pval_lt_per) begin
               cmd.val_ld  = 1'b1;
               cmd.val_src = VAL_PVAL;
               state_in    = S_LOAD_WR;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_src   = DIV_SRC_PVAL;
               state_in      = S_LOAD_DIV;
            end
         end
         S_LOAD_DIV: begin
            if (!sts.div_busy) begin
               cmd.val_ld  = 1'b1;
               cmd.val_src = VAL_REM;
               state_in    = S_LOAD_WR;
            end
         end
         S_LOAD_WR: begin
            cmd.wr_en     = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_code = ST_LOADED;
            state_in      = S_IDLE;
         end
         S_TRIAL_RD: begin
            cmd.cap_sum = 1'b1;
            state_in    = S_TRIAL_SUM;
         end
         S_TRIAL_SUM: begin
            if (sts.sum_fast_ok) begin
               cmd.val_ld  = 1'b1;
               cmd.val_src = VAL_FAST;
               cmd.idx_clr = 1'b1;
               state_in    = S_SCAN_ISSUE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_src   = DIV_SRC_SUM;
               state_in      = S_TRIAL_DIV;
            end
         end
         S_TRIAL_DIV: begin
            if (!sts.div_busy) begin
               cmd.val_ld  = 1'b1;
               cmd.val_src = VAL_REM;
               cmd.idx_clr = 1'b1;
               state_in    = S_SCAN_ISSUE;
            end
         end
         S_SCAN_ISSUE: begin
            if (sts.idx_done) begin
               state_in = S_TRIAL_WR;
            end else if (sts.idx_is_k) begin
               cmd.idx_inc = 1'b1;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_scan = 1'b1;
               state_in    = S_SCAN_DX;
            end
         end
         S_SCAN_DX: begin
            cmd.dx_ld = 1'b1;
            state_in  = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (!sts.dx_lt_per) begin
               cmd.div_start = 1'b1;
               cmd.div_src   = DIV_SRC_DX;
               state_in      = S_SCAN_DIV;
            end else if (sts.overlap) begin
               cmd.emit      = 1'b1;
               cmd.emit_code = ST_REJECT;
               state_in      = S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_ISSUE;
            end
         end
         S_SCAN_DIV: begin
            cmd.ov_from_div = 1'b1;
            if (!sts.div_busy) begin
               if (sts.overlap) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_code = ST_REJECT;
                  state_in      = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_SCAN_ISSUE;
               end
            end
         end
         S_TRIAL_WR: begin
            cmd.wr_en     = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_code = ST_ACCEPT;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      busy_in = state_in != S_IDLE;
   end

   // state and registered busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

// ----- rtl/hard_rod_metropolis_step_unit.sv -----
// hard_rod_metropolis_step_unit: top level with the configuration registers
// depends on hrms_pkg, hrms_ctrl and hrms_datapath (which holds hrms_ram and hrms_rem)
//
// Keeps up to 64 hard-rod positions (Q16.16) on a periodic line and performs one
// load or trial move per item. An item is taken when start is high and busy is low;
// its single result shows on rsp_data for one cycle with rsp_strobe and must be
// taken then, since the block cannot be held off. A load passes through decode and,
// when needed, the remainder unit before the write. A trial reads the rod, wraps the
// move and scans the store one rod at a time through the single read port, reading,
// measuring and checking each other active rod; an overlap ends the scan early. Each
// wrap or distance that reaches past one period is reduced by the bit-serial remainder
// unit. Rod positions are undefined until loaded; the user must write configuration
// only while busy is low and no result is pending; the block does not enforce this.
module hard_rod_metropolis_step_unit
   import hrms_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // command channel
   input  logic              start,
   output logic              busy,
   input  req_item_type      req_data,
   // result channel
   output logic              rsp_strobe,
   output rsp_item_type      rsp_data,
   // configuration port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   logic [POS_W-1:0]   box_ff, box_in;
   logic [POS_W-1:0]   diam_ff, diam_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               csr_write;
   csr_index_type      csr_index;
   hrms_cmd_type       cmd;
   hrms_status_type    sts;

   // configuration writes on the access phase
   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_index_type'(paddr[CSR_AW-1:2]);

   always_comb begin
      box_in   = box_ff;
      diam_in  = diam_ff;
      count_in = count_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_BOX:      box_in   = pwdata[POS_W-1:0];
            CSR_DIAMETER: diam_in  = pwdata[POS_W-1:0];
            CSR_COUNT:    count_in = pwdata[COUNT_W-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff   <= BOX_RESET;
         diam_ff  <= DIAMETER_RESET;
         count_ff <= COUNT_RESET;
      end else begin
         box_ff   <= box_in;
         diam_ff  <= diam_in;
         count_ff <= count_in;
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         CSR_BOX:      prdata = CSR_DW'(box_ff);
         CSR_DIAMETER: prdata = CSR_DW'(diam_ff);
         CSR_COUNT:    prdata = CSR_DW'(count_ff);
         default:      prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   hrms_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   hrms_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .box_length   (box_ff),
      .rod_diameter (diam_ff),
      .rod_count    (count_ff),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data)
   );

endmodule

// ----- rtl/hrms_checker.sv -----
// hrms_checker: port-level checks of the step unit over time, bound to the top level
// depends on hrms_pkg and hard_rod_metropolis_step_unit
module hrms_checker
   import hrms_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_strobe,
   input rsp_item_type rsp_data
);

   // a transfer always makes the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after a command transfer");

   // a result is shown only once the block has gone back to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // no two results in consecutive cycles, one item gives one result
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results in consecutive cycles");

   // an index beyond the rod count reports a zero position
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ST_RANGE) |-> (rsp_data.final_position == '0))
      else $error("nonzero position with range status");

   // reset leaves the block idle with no result
   assert property (@(posedge clock)
      $past(reset) |-> (!busy && !rsp_strobe))
      else $error("block not idle after reset");

endmodule

bind hard_rod_metropolis_step_unit hrms_checker u_hrms_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
